>>> design/smm_pkg.sv
`default_nettype none

package smm_pkg;

    localparam logic [2:0] MAX_WORK_RAM_BANKS = 3'd4;
    localparam logic [4:0] SHIFT_EMPTY        = 5'h10;
    localparam logic [4:0] PRG_HIGH_BIT       = 5'h10;
    localparam logic [4:0] PRG_MODE_BITS      = 5'h0C;
    localparam logic [5:0] PRG_HIGH_MIN_BANKS = 6'd16;
    localparam logic [4:0] RAM_SELECT_TWO     = 5'h08;
    localparam logic [4:0] RAM_SELECT_FOUR    = 5'h0C;
    localparam logic [1:0] RAM_SHIFT_TWO      = 2'd3;
    localparam logic [1:0] RAM_SHIFT_FOUR     = 2'd2;

    localparam int CFG_ADDR_W = 4;

    typedef enum logic [1:0] {
        CFG_PRG_ROM_BANKS = 2'd0,
        CFG_CHR_MASK      = 2'd1,
        CFG_PRG_RAM_BANKS = 2'd2,
        CFG_PATTERN_RAM   = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CMD_CPU_READ  = 2'd0,
        CMD_CPU_WRITE = 2'd1,
        CMD_PPU_READ  = 2'd2,
        CMD_PPU_WRITE = 2'd3
    } t_command;

    typedef enum logic [2:0] {
        TGT_NONE      = 3'd0,
        TGT_WORK_RAM  = 3'd1,
        TGT_PRG_ROM   = 3'd2,
        TGT_PATTERN   = 3'd3,
        TGT_NAMETABLE = 3'd4
    } t_target;

    typedef enum logic [1:0] {
        SEL_CONTROL = 2'd0,
        SEL_CHR0    = 2'd1,
        SEL_CHR1    = 2'd2,
        SEL_PRG     = 2'd3
    } t_serial_reg;

    typedef enum logic [1:0] {
        PRG_32K_A    = 2'd0,
        PRG_32K_B    = 2'd1,
        PRG_FIX_LOW  = 2'd2,
        PRG_FIX_HIGH = 2'd3
    } t_prg_mode;

    typedef enum logic [1:0] {
        MIR_SCREEN0    = 2'd0,
        MIR_SCREEN1    = 2'd1,
        MIR_VERTICAL   = 2'd2,
        MIR_HORIZONTAL = 2'd3
    } t_mirror;

    typedef struct packed {
        logic [5:0] prg_rom_bank_count;
        logic [4:0] chr_select_mask;
        logic [2:0] prg_ram_bank_count;
        logic       pattern_is_ram;
    } t_cfg;

    typedef struct packed {
        logic [4:0] serial_shift;
        logic [4:0] control_value;
        logic [4:0] chr_low_value;
        logic [4:0] chr_high_value;
        logic [4:0] prg_value;
        logic [1:0] work_ram_bank;
        logic [4:0] rom_bank_lower;
        logic [4:0] rom_bank_upper;
        logic [4:0] pattern_bank_lower;
        logic [4:0] pattern_bank_upper;
        logic       upper_bank_loaded;
    } t_state;

    typedef struct packed {
        t_target     target;
        logic [18:0] physical_address;
        logic        write_enable;
    } t_result;

endpackage

`default_nettype wire

>>> design/smm_regs.sv
`default_nettype none

module smm_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [smm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    output smm_pkg::t_cfg                        o_cfg
);

    smm_pkg::t_cfg     r_cfg;
    smm_pkg::t_cfg_reg sel;
    logic              wr_en;

    assign sel    = smm_pkg::t_cfg_reg'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prg_rom_bank_count <= 6'd2;
            r_cfg.chr_select_mask    <= 5'd1;
            r_cfg.prg_ram_bank_count <= 3'd1;
            r_cfg.pattern_is_ram     <= 1'b0;
        end else if (wr_en) begin
            case (sel)
                smm_pkg::CFG_PRG_ROM_BANKS: r_cfg.prg_rom_bank_count <= pwdata[5:0];
                smm_pkg::CFG_CHR_MASK:      r_cfg.chr_select_mask    <= pwdata[4:0];
                smm_pkg::CFG_PRG_RAM_BANKS: r_cfg.prg_ram_bank_count <= pwdata[2:0];
                smm_pkg::CFG_PATTERN_RAM:   r_cfg.pattern_is_ram     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            smm_pkg::CFG_PRG_ROM_BANKS: prdata = {26'd0, r_cfg.prg_rom_bank_count};
            smm_pkg::CFG_CHR_MASK:      prdata = {27'd0, r_cfg.chr_select_mask};
            smm_pkg::CFG_PRG_RAM_BANKS: prdata = {29'd0, r_cfg.prg_ram_bank_count};
            smm_pkg::CFG_PATTERN_RAM:   prdata = {31'd0, r_cfg.pattern_is_ram};
            default:                    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> design/smm_core.sv
`default_nettype none

module smm_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [1:0]     i_command,
    input  wire logic [15:0]    i_bus_address,
    input  wire logic [7:0]     i_write_data,
    input  smm_pkg::t_cfg       i_cfg,
    output smm_pkg::t_result    o_result
);

    smm_pkg::t_state   r_st;
    smm_pkg::t_state   n_st;
    smm_pkg::t_result  res;
    smm_pkg::t_command cmd;

    logic [4:0]  high_sel;
    logic [2:0]  ram_n;
    logic [1:0]  ram_sh;
    logic [4:0]  ram_sel;
    logic [4:0]  last_bank;
    logic [4:0]  shift_v;
    logic [4:0]  copy_bits;
    logic [4:0]  keep;
    logic [1:0]  ram_bank_v;
    logic [13:0] pp;
    logic [4:0]  rom_bank;
    logic [4:0]  pat_bank;
    logic        screen;

    function automatic smm_pkg::t_state prg_refresh(
        input smm_pkg::t_state s,
        input logic [4:0]      hs,
        input logic [4:0]      lb
    );
        smm_pkg::t_state r;
        logic [4:0]      b;
        r = s;
        b = (s.chr_low_value & hs) | {1'b0, s.prg_value[3:0]};
        case (smm_pkg::t_prg_mode'(s.control_value[3:2]))
            smm_pkg::PRG_FIX_LOW: begin
                r.rom_bank_lower = 5'd0;
                r.rom_bank_upper = b;
            end
            smm_pkg::PRG_FIX_HIGH: begin
                r.rom_bank_lower = b;
                r.rom_bank_upper = lb;
            end
            default: begin
                r.rom_bank_lower = {b[4:1], 1'b0};
                r.rom_bank_upper = {b[4:1], 1'b1};
            end
        endcase
        r.upper_bank_loaded = 1'b1;
        return r;
    endfunction

    function automatic smm_pkg::t_state chr_refresh(
        input smm_pkg::t_state s,
        input logic [4:0]      m
    );
        smm_pkg::t_state r;
        logic [4:0]      lo;
        r  = s;
        lo = s.chr_low_value & m;
        if (s.control_value[4]) begin
            r.pattern_bank_lower = lo;
            r.pattern_bank_upper = s.chr_high_value & m;
        end else begin
            r.pattern_bank_lower = {lo[4:1], 1'b0};
            r.pattern_bank_upper = {lo[4:1], 1'b1};
        end
        return r;
    endfunction

    assign cmd       = smm_pkg::t_command'(i_command);
    assign high_sel  = (i_cfg.prg_rom_bank_count > smm_pkg::PRG_HIGH_MIN_BANKS)
                       ? smm_pkg::PRG_HIGH_BIT : 5'd0;
    assign ram_n     = (i_cfg.prg_ram_bank_count > smm_pkg::MAX_WORK_RAM_BANKS)
                       ? smm_pkg::MAX_WORK_RAM_BANKS : i_cfg.prg_ram_bank_count;
    assign ram_sh    = (ram_n > 3'd2) ? smm_pkg::RAM_SHIFT_FOUR : smm_pkg::RAM_SHIFT_TWO;
    assign ram_sel   = (ram_n <= 3'd1) ? 5'd0 :
                       (ram_n == 3'd2) ? smm_pkg::RAM_SELECT_TWO : smm_pkg::RAM_SELECT_FOUR;
    assign last_bank = 5'(i_cfg.prg_rom_bank_count - 6'd1);
    assign shift_v   = {i_write_data[0], r_st.serial_shift[4:1]};
    assign copy_bits = shift_v & (ram_sel | high_sel);
    assign keep      = i_cfg.chr_select_mask;
    assign ram_bank_v = 2'((shift_v & ram_sel) >> ram_sh);
    assign pp        = i_bus_address[13:0];
    assign rom_bank  = !i_bus_address[14] ? r_st.rom_bank_lower :
                       r_st.upper_bank_loaded ? r_st.rom_bank_upper : last_bank;
    assign pat_bank  = pp[12] ? r_st.pattern_bank_upper : r_st.pattern_bank_lower;

    always_comb begin
        case (smm_pkg::t_mirror'(r_st.control_value[1:0]))
            smm_pkg::MIR_SCREEN0:    screen = 1'b0;
            smm_pkg::MIR_SCREEN1:    screen = 1'b1;
            smm_pkg::MIR_VERTICAL:   screen = pp[10];
            smm_pkg::MIR_HORIZONTAL: screen = pp[11];
            default:                 screen = 1'b0;
        endcase
    end

    always_comb begin
        res.target           = smm_pkg::TGT_NONE;
        res.physical_address = '0;
        res.write_enable     = 1'b0;
        case (cmd)
            smm_pkg::CMD_CPU_READ, smm_pkg::CMD_CPU_WRITE: begin
                if (i_bus_address[15:13] == 3'b011) begin
                    if (ram_n != 3'd0 && !r_st.prg_value[4]) begin
                        res.target           = smm_pkg::TGT_WORK_RAM;
                        res.physical_address = {4'd0, r_st.work_ram_bank,
                                                i_bus_address[12:0]};
                        res.write_enable     = (cmd == smm_pkg::CMD_CPU_WRITE);
                    end
                end else if (i_bus_address[15] && cmd == smm_pkg::CMD_CPU_READ) begin
                    res.target           = smm_pkg::TGT_PRG_ROM;
                    res.physical_address = {rom_bank, i_bus_address[13:0]};
                end
            end
            smm_pkg::CMD_PPU_READ, smm_pkg::CMD_PPU_WRITE: begin
                if (pp[13]) begin
                    res.target           = smm_pkg::TGT_NAMETABLE;
                    res.physical_address = {8'd0, screen, pp[9:0]};
                    res.write_enable     = (cmd == smm_pkg::CMD_PPU_WRITE);
                end else begin
                    res.target           = smm_pkg::TGT_PATTERN;
                    res.physical_address = {2'd0, pat_bank, pp[11:0]};
                    res.write_enable     = (cmd == smm_pkg::CMD_PPU_WRITE)
                                           & i_cfg.pattern_is_ram;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_st = r_st;
        if (cmd == smm_pkg::CMD_CPU_WRITE && i_bus_address[15]) begin
            if (i_write_data[7]) begin
                n_st.serial_shift  = smm_pkg::SHIFT_EMPTY;
                n_st.control_value = r_st.control_value | smm_pkg::PRG_MODE_BITS;
                n_st = prg_refresh(n_st, high_sel, last_bank);
            end else if (!r_st.serial_shift[0]) begin
                n_st.serial_shift = shift_v;
            end else begin
                n_st.serial_shift = smm_pkg::SHIFT_EMPTY;
                case (smm_pkg::t_serial_reg'(i_bus_address[14:13]))
                    smm_pkg::SEL_CONTROL: begin
                        n_st.control_value = shift_v;
                        n_st = chr_refresh(n_st, keep);
                        n_st = prg_refresh(n_st, high_sel, last_bank);
                    end
                    smm_pkg::SEL_CHR0: begin
                        n_st.chr_low_value  = shift_v;
                        n_st.chr_high_value = (r_st.chr_high_value & keep) | copy_bits;
                        n_st = chr_refresh(n_st, keep);
                        n_st.work_ram_bank  = ram_bank_v;
                        n_st = prg_refresh(n_st, high_sel, last_bank);
                    end
                    smm_pkg::SEL_CHR1: begin
                        n_st.chr_high_value = shift_v;
                        n_st.chr_low_value  = (r_st.chr_low_value & keep) | copy_bits;
                        n_st = chr_refresh(n_st, keep);
                        n_st.work_ram_bank  = ram_bank_v;
                        n_st = prg_refresh(n_st, high_sel, last_bank);
                    end
                    smm_pkg::SEL_PRG: begin
                        n_st.prg_value = shift_v;
                        n_st = prg_refresh(n_st, high_sel, last_bank);
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.serial_shift       <= smm_pkg::SHIFT_EMPTY;
            r_st.control_value      <= smm_pkg::PRG_MODE_BITS;
            r_st.chr_low_value      <= '0;
            r_st.chr_high_value     <= '0;
            r_st.prg_value          <= '0;
            r_st.work_ram_bank      <= '0;
            r_st.rom_bank_lower     <= '0;
            r_st.rom_bank_upper     <= '0;
            r_st.pattern_bank_lower <= '0;
            r_st.pattern_bank_upper <= '0;
            r_st.upper_bank_loaded  <= 1'b0;
        end else if (i_accept) begin
            r_st <= n_st;
        end
    end

    assign o_result = res;

`ifndef ASSERT_OFF
    a_marker_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.serial_shift != 5'd0)
        else $error("serial shift register lost its marker bit");

    a_idle_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_st))
        else $error("mapper state changed without a request");

    a_reset_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && cmd == smm_pkg::CMD_CPU_WRITE && i_bus_address[15] && i_write_data[7]
        |=> r_st.serial_shift == smm_pkg::SHIFT_EMPTY
            && r_st.control_value[3:2] == 2'b11 && r_st.upper_bank_loaded)
        else $error("serial reset write did not force fix-high mode");

    a_upper_loaded_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.upper_bank_loaded |=> r_st.upper_bank_loaded)
        else $error("upper bank loaded flag cleared outside reset");
`endif

endmodule

`default_nettype wire

>>> design/serial_bank_switch_mapper.sv
// The result of an accepted request is registered and appears on the outputs in the cycle after acceptance.
// One request per cycle while o_in_stall is low; decode and bank registers update in a single stage.
// Input stall is raised only while the result register is full and stalled.
// Reset: synchronous, active low; restores the config registers to their defaults,
// the shift register to its marker value, control to fix-high, all banks to zero.
`default_nettype none

module serial_bank_switch_mapper (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [smm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [1:0]                      i_command,
    input  wire logic [15:0]                     i_bus_address,
    input  wire logic [7:0]                      i_write_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [2:0]                           o_target,
    output logic [18:0]                          o_physical_address,
    output logic                                 o_write_enable
);

    smm_pkg::t_cfg    cfg;
    smm_pkg::t_result result;
    smm_pkg::t_result r_out;
    logic             r_out_valid;
    logic             accept;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    smm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    smm_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_command     (i_command),
        .i_bus_address (i_bus_address),
        .i_write_data  (i_write_data),
        .i_cfg         (cfg),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_target           = r_out.target;
    assign o_physical_address = r_out.physical_address;
    assign o_write_enable     = r_out.write_enable;

endmodule

`default_nettype wire
